FILE: src/id_set_table_with_sort_top_assert.svh
// Assertion macros for the ID set table.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef ID_SET_TABLE_WITH_SORT_TOP_ASSERT_SVH
`define ID_SET_TABLE_WITH_SORT_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define ISTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ISTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ISTS_ASSERT(label, prop, msg)
`define ISTS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: src/ists_pkg.sv
// Shared constants, opcodes and the comb sort gap shrink for the ID set table.
// No dependencies.
package ists_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_W     = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 3;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_SORT   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  // gap*10/13 as gap * (10 * ceil(2^16/13)) >> 16, exact for gap*10 below 6553
  localparam int GAP_SHIFT = 16;
  localparam int GAP_MUL   = 10 * ((1 << GAP_SHIFT) / 13 + 1);
  localparam int GAP_PW    = CNT_W + GAP_SHIFT + 4;

  function automatic logic [CNT_W-1:0] gap_shrink(input logic [CNT_W-1:0] gap);
    logic [GAP_PW-1:0] prod;
    prod = GAP_PW'(gap) * GAP_PW'(GAP_MUL);
    return prod[GAP_SHIFT +: CNT_W];
  endfunction

endpackage

FILE: src/ists_req_if.sv
// Request channel of the ID set table: valid/ready plus command payload.
// Depends on ists_pkg.
interface ists_req_if;
  logic                      valid;
  logic                      ready;
  logic [ists_pkg::OP_W-1:0] op;
  logic [ists_pkg::ID_W-1:0] id;
  logic [ists_pkg::IDX_W-1:0] index;

  modport source (output valid, op, id, index, input ready);
  modport sink   (input valid, op, id, index, output ready);
endinterface

FILE: src/ists_rsp_if.sv
// Response channel of the ID set table: valid/ready plus result payload.
// Depends on ists_pkg.
interface ists_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic                       full_res;
  logic [ists_pkg::ID_W-1:0]  entry_id;
  logic                       entry_valid;
  logic [ists_pkg::CNT_W-1:0] count;

  modport source (output valid, found, full_res, entry_id, entry_valid, count, input ready);
  modport sink   (input valid, found, full_res, entry_id, entry_valid, count, output ready);
endinterface

FILE: src/ists_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ists_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/id_set_table_with_sort_top.sv
// ID set table: packed list of unique IDs in one RAM, with a sequencer.
// Depends on ists_pkg, ists_req_if, ists_rsp_if, ists_ram and the assert header.
//
// Usage: commands arrive on req_i (op, id, index), one result per command
// leaves on rsp_o. Both channels move a request when valid and ready are high.
// The block takes one command at a time; req_i.ready is high while idle, even
// while an earlier result still waits in the output register.
// Operation, with n the stored count, all through the single RAM read port:
//   insert, lookup: scan of up to n entries, one entry compared per cycle
//   delete: scan, then on a hit read of the last entry and move
//   read: one RAM read, none past the count; unused opcodes: result only
//   sort: comb sort passes, each pair read, compared and swapped if needed
// Reset clears the count and the handshake state; the RAM is not cleared,
// only positions below the count are ever read.
// A stalled receiver holds the result in the output register; the next
// command is taken but finishes only once that result has left.
module id_set_table_with_sort_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ists_req_if.sink   req_i,
  ists_rsp_if.source rsp_o
);
  import ists_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SCAN   = 4'd1;
  localparam logic [3:0] ST_DEL_RD = 4'd2;
  localparam logic [3:0] ST_DEL_WR = 4'd3;
  localparam logic [3:0] ST_READ   = 4'd4;
  localparam logic [3:0] ST_GAP    = 4'd5;
  localparam logic [3:0] ST_NEXT   = 4'd6;
  localparam logic [3:0] ST_RDA    = 4'd7;
  localparam logic [3:0] ST_RDB    = 4'd8;
  localparam logic [3:0] ST_CMP    = 4'd9;
  localparam logic [3:0] ST_SWB    = 4'd10;
  localparam logic [3:0] ST_RES    = 4'd11;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [OP_W-1:0]  op_q, op_d;
  logic [ID_W-1:0]  key_q, key_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] rd_q, rd_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0] gap_q, gap_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             swap_q, swap_d;
  logic [ID_W-1:0]  a_q, a_d;

  logic             res_found_q, res_found_d;
  logic             res_full_q, res_full_d;
  logic [ID_W-1:0]  res_eid_q, res_eid_d;
  logic             res_evld_q, res_evld_d;

  logic             out_vld_q, out_vld_d;
  logic             out_found_q, out_full_q, out_evld_q;
  logic [ID_W-1:0]  out_eid_q;
  logic [CNT_W-1:0] out_cnt_q;
  logic             out_load;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ID_W-1:0]  ram_wdata, ram_rdata;

  logic             req_acc;
  logic [CNT_W:0]   pair_end;
  logic [CNT_W-1:0] gap_new;

  assign req_acc  = req_i.valid && req_i.ready;
  assign pair_end = {1'b0, k_q} + {1'b0, gap_q};
  assign gap_new  = gap_shrink(gap_q);
  assign out_load = (state_q == ST_RES) && (!out_vld_q || rsp_o.ready);

  ists_ram #(
    .WIDTH (ID_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    key_d       = key_q;
    pos_d       = pos_q;
    rd_d        = rd_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_idx_d   = cmp_idx_q;
    slot_d      = slot_q;
    gap_d       = gap_q;
    k_d         = k_q;
    swap_d      = swap_q;
    a_d         = a_q;
    res_found_d = res_found_q;
    res_full_d  = res_full_q;
    res_eid_d   = res_eid_q;
    res_evld_d  = res_evld_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          op_d        = req_i.op;
          key_d       = req_i.id;
          pos_d       = req_i.index;
          rd_d        = '0;
          cmp_vld_d   = 1'b0;
          res_found_d = 1'b0;
          res_full_d  = 1'b0;
          res_eid_d   = '0;
          res_evld_d  = 1'b0;
          case (req_i.op)
            OP_INSERT, OP_LOOKUP, OP_DELETE: state_d = ST_SCAN;
            OP_SORT: begin
              gap_d   = cnt_q;
              state_d = ST_GAP;
            end
            OP_READ: begin
              if (CNT_W'(req_i.index) < cnt_q) begin
                ram_re    = 1'b1;
                ram_raddr = req_i.index;
                state_d   = ST_READ;
              end else begin
                state_d = ST_RES;
              end
            end
            default: state_d = ST_RES;
          endcase
        end
      end

      // issue one read per cycle and compare the entry read the cycle before
      ST_SCAN: begin
        if (cmp_vld_q && ram_rdata == key_q) begin
          case (op_q)
            OP_DELETE: begin
              slot_d  = cmp_idx_q;
              state_d = ST_DEL_RD;
            end
            default: begin
              res_found_d = 1'b1;
              state_d     = ST_RES;
            end
          endcase
        end else if (rd_q < cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = rd_q[IDX_W-1:0];
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_q[IDX_W-1:0];
          rd_d      = rd_q + 1'b1;
        end else if (cmp_vld_q) begin
          cmp_vld_d = 1'b0;
        end else begin
          // miss: only insert changes the table
          if (op_q == OP_INSERT) begin
            if (cnt_q == CNT_W'(CAPACITY)) begin
              res_full_d = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = cnt_q[IDX_W-1:0];
              ram_wdata = key_q;
              cnt_d     = cnt_q + 1'b1;
            end
          end
          state_d = ST_RES;
        end
      end

      ST_DEL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(cnt_q - 1'b1);
        state_d   = ST_DEL_WR;
      end

      // move the last entry into the freed slot
      ST_DEL_WR: begin
        ram_we      = 1'b1;
        ram_waddr   = slot_q;
        ram_wdata   = ram_rdata;
        cnt_d       = cnt_q - 1'b1;
        res_found_d = 1'b1;
        state_d     = ST_RES;
      end

      ST_READ: begin
        res_eid_d  = ram_rdata;
        res_evld_d = 1'b1;
        state_d    = ST_RES;
      end

      ST_GAP: begin
        gap_d   = (gap_new <= CNT_W'(1)) ? CNT_W'(1) : gap_new;
        k_d     = '0;
        swap_d  = 1'b0;
        state_d = ST_NEXT;
      end

      ST_NEXT: begin
        if (pair_end < {1'b0, cnt_q}) begin
          state_d = ST_RDA;
        end else if (gap_q == CNT_W'(1) && !swap_q) begin
          state_d = ST_RES;
        end else begin
          state_d = ST_GAP;
        end
      end

      ST_RDA: begin
        ram_re    = 1'b1;
        ram_raddr = k_q[IDX_W-1:0];
        state_d   = ST_RDB;
      end

      ST_RDB: begin
        ram_re    = 1'b1;
        ram_raddr = pair_end[IDX_W-1:0];
        a_d       = ram_rdata;
        state_d   = ST_CMP;
      end

      // swap: write the smaller entry low now, the larger one next cycle
      ST_CMP: begin
        if (a_q > ram_rdata) begin
          ram_we    = 1'b1;
          ram_waddr = k_q[IDX_W-1:0];
          ram_wdata = ram_rdata;
          swap_d    = 1'b1;
          state_d   = ST_SWB;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_NEXT;
        end
      end

      ST_SWB: begin
        ram_we    = 1'b1;
        ram_waddr = pair_end[IDX_W-1:0];
        ram_wdata = a_q;
        k_d       = k_q + 1'b1;
        state_d   = ST_NEXT;
      end

      ST_RES: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    pos_q       <= pos_d;
    rd_q        <= rd_d;
    cmp_vld_q   <= cmp_vld_d;
    cmp_idx_q   <= cmp_idx_d;
    slot_q      <= slot_d;
    gap_q       <= gap_d;
    k_q         <= k_d;
    swap_q      <= swap_d;
    a_q         <= a_d;
    res_found_q <= res_found_d;
    res_full_q  <= res_full_d;
    res_eid_q   <= res_eid_d;
    res_evld_q  <= res_evld_d;
    if (out_load) begin
      out_found_q <= res_found_q;
      out_full_q  <= res_full_q;
      out_eid_q   <= res_eid_q;
      out_evld_q  <= res_evld_q;
      out_cnt_q   <= cnt_q;
    end
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.found       = out_found_q;
  assign rsp_o.full_res    = out_full_q;
  assign rsp_o.entry_id    = out_eid_q;
  assign rsp_o.entry_valid = out_evld_q;
  assign rsp_o.count       = out_cnt_q;

`include "id_set_table_with_sort_top_assert.svh"

  `ISTS_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(CAPACITY), "entry count above capacity")
  `ISTS_ASSERT(a_cnt_idle, (state_q == ST_IDLE) |=> (cnt_q == $past(cnt_q)), "count moved while idle")
  `ISTS_ASSERT(a_res_load, out_load |=> out_vld_q, "result not presented after load")
  `ISTS_ASSERT(a_rd_pos, (state_q == ST_READ) |-> (CNT_W'(pos_q) < cnt_q), "read past the count")
  `ISTS_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> (state_q == ST_IDLE && !out_vld_q), "not idle in reset")

endmodule

FILE: tb/tb_id_set_table_with_sort_top.sv
// Self-checking testbench for id_set_table_with_sort_top: directed and random table
// requests, each predicted from a copy of the ID list kept in the bench.
// Depends on ists_pkg, ists_req_if, ists_rsp_if and the block itself.
module tb_id_set_table_with_sort_top;
  import ists_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = OP_READ + 3'd1;
  localparam logic [OP_W-1:0] OP_SPARE_HI = '1;
  localparam int IDLE_LIMIT  = 100000;
  localparam int NUM_RANDOM  = 1150;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_SHOWN   = 100;

  typedef struct packed {
    logic             found;
    logic             full_res;
    logic [ID_W-1:0]  entry_id;
    logic             entry_valid;
    logic [CNT_W-1:0] count;
  } table_result_t;

  // Keeps the packed ID list as the block should hold it, and the results still owed.
  class id_set_tracker;
    logic [ID_W-1:0] stored_ids[$];
    table_result_t   owed_results[$];
    int              errors;

    function int slot_of(logic [ID_W-1:0] id);
      foreach (stored_ids[k]) begin
        if (stored_ids[k] == id) return k;
      end
      return -1;
    endfunction

    function void take_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                               logic [IDX_W-1:0] index);
      table_result_t r;
      int            slot;
      r    = '0;
      slot = slot_of(id);
      case (op)
        OP_INSERT: begin
          if (slot >= 0) r.found = 1'b1;
          else if (stored_ids.size() >= CAPACITY) r.full_res = 1'b1;
          else stored_ids.push_back(id);
        end
        OP_LOOKUP: r.found = (slot >= 0);
        OP_DELETE: begin
          if (slot >= 0) begin
            // move the last entry into the freed slot
            stored_ids[slot] = stored_ids[stored_ids.size()-1];
            void'(stored_ids.pop_back());
            r.found = 1'b1;
          end
        end
        // IDs are distinct, so any comb sort gap sequence ends in plain ascending order
        OP_SORT: stored_ids.sort();
        OP_READ: begin
          if (index < stored_ids.size()) begin
            r.entry_valid = 1'b1;
            r.entry_id    = stored_ids[index];
          end
        end
        default: ;
      endcase
      r.count = CNT_W'(stored_ids.size());
      owed_results.push_back(r);
    endfunction

    task report(string what, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
      if (errors < MAX_SHOWN)
        $display("mismatch on %s: expected %0h, got %0h", what, want, got);
      errors++;
    endtask

    task match_result(table_result_t got);
      table_result_t want;
      if (owed_results.size() == 0) begin
        report("unexpected result, count", '0, ID_W'(got.count));
        return;
      end
      want = owed_results.pop_front();
      if (got.found !== want.found) report("found", ID_W'(want.found), ID_W'(got.found));
      if (got.full_res !== want.full_res)
        report("full_res", ID_W'(want.full_res), ID_W'(got.full_res));
      if (got.entry_id !== want.entry_id) report("entry_id", want.entry_id, got.entry_id);
      if (got.entry_valid !== want.entry_valid)
        report("entry_valid", ID_W'(want.entry_valid), ID_W'(got.entry_valid));
      if (got.count !== want.count) report("count", ID_W'(want.count), ID_W'(got.count));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  ists_req_if req_if();
  ists_rsp_if rsp_if();

  id_set_table_with_sort_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  id_set_tracker tracker = new();
  int  sent;
  int  received;
  int  idle_cycles;
  bit  send_steady;
  bit  recv_steady;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic send_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                              logic [IDX_W-1:0] index);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.id    <= id;
    req_if.index <= index;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    tracker.take_request(op, id, index);
    sent++;
    if (sent % 40 == 0) send_steady = ($urandom_range(0, 3) == 0);
  endtask

  // Mix IDs already stored, corner values and fully random ones.
  function automatic logic [ID_W-1:0] pick_id();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5 && tracker.stored_ids.size() > 0)
      return tracker.stored_ids[$urandom_range(0, tracker.stored_ids.size() - 1)];
    case (sel % 4)
      0: return '0;
      1: return '1;
      2: return ID_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int n;
    n = tracker.stored_ids.size();
    if (n > 0 && $urandom_range(0, 9) < 7) return IDX_W'($urandom_range(0, n - 1));
    return IDX_W'($urandom_range(0, CAPACITY - 1));
  endfunction

  // Stimulus and end of run.
  initial begin
    int          phase;
    int          roll;
    int          ins_pct;
    int          del_pct;
    logic [OP_W-1:0] op;
    req_if.valid <= 1'b0;
    req_if.op    <= OP_INSERT;
    req_if.id    <= '0;
    req_if.index <= '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table corners
    send_request(OP_READ, '0, '0);
    send_request(OP_SORT, '0, '0);
    send_request(OP_DELETE, 32'h0000_0005, '0);
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_INSERT, '1, '0);
    send_request(OP_SORT, '0, '0);
    send_request(OP_INSERT, '0, '1);
    send_request(OP_INSERT, '1, '0);
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_LOOKUP, 32'h0000_0001, '0);
    send_request(OP_INSERT, 32'h8000_0000, '0);
    send_request(OP_INSERT, 32'h7FFF_FFFF, '0);
    send_request(OP_INSERT, 32'h5555_5555, '0);
    send_request(OP_INSERT, 32'hAAAA_AAAA, '0);
    send_request(OP_SORT, '0, '0);
    send_request(OP_READ, '0, 6'd0);
    send_request(OP_READ, '0, 6'd5);
    send_request(OP_READ, '0, '1);
    send_request(OP_DELETE, '0, '0);
    send_request(OP_DELETE, 32'h1234_5678, '0);
    send_request(OP_DELETE, tracker.stored_ids[tracker.stored_ids.size()-1], '0);
    for (int k = OP_SPARE_LO; k <= OP_SPARE_HI; k++)
      send_request(OP_W'(k), $urandom, IDX_W'($urandom_range(0, CAPACITY - 1)));

    // fill to capacity, then refused and duplicate inserts and a full sort
    while (tracker.stored_ids.size() < CAPACITY)
      send_request(OP_INSERT, $urandom, '0);
    send_request(OP_INSERT, $urandom, '0);
    send_request(OP_INSERT, tracker.stored_ids[0], '0);
    send_request(OP_READ, '0, '1);
    send_request(OP_SORT, '0, '0);
    send_request(OP_READ, '0, '0);
    send_request(OP_READ, '0, '1);

    // phases that grow, churn and shrink the table
    for (int n = 0; n < NUM_RANDOM; n++) begin
      phase   = (n / 100) % 3;
      ins_pct = (phase == 0) ? 60 : (phase == 1) ? 30 : 10;
      del_pct = (phase == 0) ? 8 : (phase == 1) ? 25 : 50;
      roll    = $urandom_range(0, 99);
      if (roll < ins_pct) op = OP_INSERT;
      else if (roll < ins_pct + del_pct) op = OP_DELETE;
      else if (roll < ins_pct + del_pct + 15) op = OP_LOOKUP;
      else if (roll < 96) op = OP_READ;
      else if (roll < 98) op = OP_SORT;
      else op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      send_request(op, pick_id(), pick_index());
    end
    req_if.valid <= 1'b0;

    while (tracker.owed_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("tb_id_set_table_with_sort_top: done, clean");
    end else begin
      $display("tb_id_set_table_with_sort_top: done, errors");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off to back the block up.
  initial begin
    int            gap;
    table_result_t got;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      if (received == HOLD_AT) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = recv_steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      got.found       = rsp_if.found;
      got.full_res    = rsp_if.full_res;
      got.entry_id    = rsp_if.entry_id;
      got.entry_valid = rsp_if.entry_valid;
      got.count       = rsp_if.count;
      tracker.match_result(got);
      received++;
      if (received % 30 == 0) recv_steady = ($urandom_range(0, 3) == 0);
    end
  end

  // Abort when neither channel has moved a request for too long.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_id_set_table_with_sort_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
